### design/dst_pkg.sv
// ----------------------------------------------------------------------------
// Device sighting table package
// Shared types, codes and defaults of the sighting table controller and
// datapath.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int TABLE_ENTRIES_DEF      = 32;
    localparam int MEAN_FRACTION_BITS_DEF = 8;
    localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd60000;

    localparam logic [1:0] MODE_SIGHT = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef enum logic [2:0] {
        EV_UPDATED  = 3'd0,
        EV_INSERTED = 3'd1,
        EV_FULL     = 3'd2,
        EV_LOST     = 3'd3,
        EV_DONE     = 3'd4
    } ev_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_MUL,
        ST_DIVLD,
        ST_DIV,
        ST_HITWR,
        ST_HITEM,
        ST_MISS,
        ST_NEWEM,
        ST_FULLEM,
        ST_AG1,
        ST_AG2CHK,
        ST_AG2EM,
        ST_DONEEM
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic scan_age;
        logic sweep_start;
        logic sweep_read;
        logic idx_inc;
        logic mul;
        logic div_load;
        logic div_step;
        logic write_hit;
        logic write_new;
        logic clr_new;
        logic clr_all;
        logic emit;
        ev_t  emit_ev;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic cmp_last;
        logic free_found;
        logic expire_here;
        logic idx_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### design/dst_ctrl.sv
// ----------------------------------------------------------------------------
// Sighting table controller
// State machine that sequences search, mean update, insertion, ageing, clears and result emission.
// ----------------------------------------------------------------------------
module dst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    input  dst_pkg::status_t  stat,
    output dst_pkg::cmd_t     cmd
);

    dst_pkg::state_t state_reg;
    dst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_ev = dst_pkg::EV_DONE;
        in_ready   = 1'b0;
        case (state_reg)
            dst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_mode)
                        dst_pkg::MODE_SIGHT:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = dst_pkg::ST_SRCH;
                        end
                        dst_pkg::MODE_BEGIN:
                        begin
                            cmd.clr_new = 1'b1;
                            state_next  = dst_pkg::ST_DONEEM;
                        end
                        dst_pkg::MODE_END:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = dst_pkg::ST_AG1;
                        end
                        default:
                        begin
                            cmd.clr_all = 1'b1;
                            state_next  = dst_pkg::ST_DONEEM;
                        end
                    endcase
                end
            end
            dst_pkg::ST_SRCH:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = dst_pkg::ST_MUL;
                end
                else if (stat.cmp_last)
                begin
                    state_next = dst_pkg::ST_MISS;
                end
            end
            dst_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = dst_pkg::ST_DIVLD;
            end
            dst_pkg::ST_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = dst_pkg::ST_DIV;
            end
            dst_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = dst_pkg::ST_HITWR;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            dst_pkg::ST_HITWR:
            begin
                cmd.write_hit = 1'b1;
                state_next    = dst_pkg::ST_HITEM;
            end
            dst_pkg::ST_HITEM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = dst_pkg::EV_UPDATED;
                    cmd.emit_last = 1'b1;
                    state_next    = dst_pkg::ST_IDLE;
                end
            end
            dst_pkg::ST_MISS:
            begin
                if (stat.free_found)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = dst_pkg::ST_NEWEM;
                end
                else
                begin
                    state_next = dst_pkg::ST_FULLEM;
                end
            end
            dst_pkg::ST_NEWEM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = dst_pkg::EV_INSERTED;
                    cmd.emit_last = 1'b1;
                    state_next    = dst_pkg::ST_IDLE;
                end
            end
            dst_pkg::ST_FULLEM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = dst_pkg::EV_FULL;
                    cmd.emit_last = 1'b1;
                    state_next    = dst_pkg::ST_IDLE;
                end
            end
            dst_pkg::ST_AG1:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_age  = 1'b1;
                if (stat.cmp_last)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = dst_pkg::ST_AG2CHK;
                end
            end
            dst_pkg::ST_AG2CHK:
            begin
                if (stat.expire_here)
                begin
                    cmd.sweep_read = 1'b1;
                    state_next     = dst_pkg::ST_AG2EM;
                end
                else if (stat.idx_last)
                begin
                    state_next = dst_pkg::ST_DONEEM;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            dst_pkg::ST_AG2EM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.emit_ev = dst_pkg::EV_LOST;
                    if (stat.idx_last)
                    begin
                        state_next = dst_pkg::ST_DONEEM;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = dst_pkg::ST_AG2CHK;
                    end
                end
            end
            dst_pkg::ST_DONEEM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = dst_pkg::EV_DONE;
                    cmd.emit_last = 1'b1;
                    state_next    = dst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/dst_dp.sv
// ----------------------------------------------------------------------------
// Sighting table datapath
// Entry memory, valid and new marks, search pipeline, mean divider and the
// result register.
// ----------------------------------------------------------------------------
module dst_dp
#(
    parameter int TABLE_ENTRIES      = dst_pkg::TABLE_ENTRIES_DEF,
    parameter int MEAN_FRACTION_BITS = dst_pkg::MEAN_FRACTION_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dst_pkg::cmd_t     cmd,
    output dst_pkg::status_t  stat,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [47:0]       in_mac,
    input  logic [7:0]        in_rssi,
    input  logic [7:0]        in_chan,
    input  logic [1:0]        in_kind,
    input  logic              in_bt,
    input  logic [31:0]       in_now,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [2:0]        out_event,
    output logic [47:0]       out_mac,
    output logic [4:0]        out_slot,
    output logic [15:0]       out_count,
    output logic [15:0]       out_mean,
    output logic [5:0]        out_in_use,
    output logic              out_last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int MW = 8 + MEAN_FRACTION_BITS;
    localparam int AW = MW + 18;
    localparam int DCW = $clog2(AW + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // Entry memory, one array per field, all at the same address.
    logic [47:0]          mem_addr  [TABLE_ENTRIES];
    logic [7:0]           mem_lrssi [TABLE_ENTRIES];
    logic signed [MW-1:0] mem_mean  [TABLE_ENTRIES];
    logic [15:0]          mem_cnt   [TABLE_ENTRIES];
    logic [31:0]          mem_first [TABLE_ENTRIES];
    logic [31:0]          mem_last  [TABLE_ENTRIES];
    logic [7:0]           mem_chan  [TABLE_ENTRIES];
    logic [1:0]           mem_kind  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] new_reg;
    logic [TABLE_ENTRIES-1:0] expire_reg;
    logic [CW-1:0]            in_use_reg;
    logic [31:0]              timeout_reg;
    logic [IW-1:0]            rd_idx_reg;
    logic [IW-1:0]            cmp_idx_reg;
    logic [IW-1:0]            hit_idx_reg;
    logic [IW-1:0]            free_idx_reg;
    logic                     iss_reg;
    logic                     cmp_vld_reg;
    logic                     free_found_reg;
    logic [DCW-1:0]           div_cnt_reg;
    logic                     out_valid_reg;

    logic [47:0]          mac_reg;
    logic [7:0]           rssi_reg;
    logic [7:0]           chan_reg;
    logic [1:0]           kind_reg;
    logic                 bt_reg;
    logic [31:0]          now_reg;
    logic [47:0]          rd_addr_reg;
    logic signed [MW-1:0] rd_mean_reg;
    logic [15:0]          rd_cnt_reg;
    logic [31:0]          rd_last_reg;
    logic signed [MW-1:0] ent_mean_reg;
    logic [15:0]          ent_cnt_reg;
    logic signed [AW-1:0] acc_reg;
    logic [15:0]          n_reg;
    logic [AW-1:0]        div_q_reg;
    logic [15:0]          div_rem_reg;
    logic                 neg_reg;

    logic [2:0]  out_event_reg;
    logic [47:0] out_mac_reg;
    logic [4:0]  out_slot_reg;
    logic [15:0] out_count_reg;
    logic [15:0] out_mean_reg;
    logic [5:0]  out_in_use_reg;
    logic        out_last_reg;

    logic                 cmp_hit;
    logic                 cmp_expired;
    logic                 rd_en;
    logic [15:0]          n_calc;
    logic [15:0]          nm1;
    logic signed [MW+16:0] prod;
    logic signed [MW-1:0] rssi_sh;
    logic signed [AW-1:0] acc_calc;
    logic [16:0]          rem_sh;
    logic [AW-1:0]        q_signed;
    logic signed [MW-1:0] div_mean;

    assign cmp_hit     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_addr_reg == mac_reg);
    assign cmp_expired = cmp_vld_reg && valid_reg[cmp_idx_reg]
                         && ((now_reg - rd_last_reg) > timeout_reg);
    assign rd_en       = (cmd.scan_step && iss_reg) || cmd.sweep_read;

    assign n_calc   = (ent_cnt_reg == 16'hFFFF) ? ent_cnt_reg : ent_cnt_reg + 16'd1;
    assign nm1      = n_calc - 16'd1;
    assign prod     = ent_mean_reg * $signed({1'b0, nm1});
    assign rssi_sh  = MW'($signed(rssi_reg)) <<< MEAN_FRACTION_BITS;
    assign acc_calc = AW'(prod) + AW'(rssi_sh);
    assign rem_sh   = {div_rem_reg, div_q_reg[AW-1]};
    assign q_signed = neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;
    assign div_mean = q_signed[MW-1:0];

    assign stat.hit         = cmp_hit && !cmd.scan_age;
    assign stat.cmp_last    = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.free_found  = free_found_reg;
    assign stat.expire_here = expire_reg[rd_idx_reg];
    assign stat.idx_last    = (rd_idx_reg == LAST_IDX);
    assign stat.div_done    = (div_cnt_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            new_reg        <= '0;
            expire_reg     <= '0;
            in_use_reg     <= '0;
            timeout_reg    <= dst_pkg::IDLE_TIMEOUT_RESET;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            iss_reg        <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.scan_start)
            begin
                rd_idx_reg     <= '0;
                iss_reg        <= 1'b1;
                cmp_vld_reg    <= 1'b0;
                free_found_reg <= 1'b0;
                expire_reg     <= '0;
            end
            if (cmd.scan_step)
            begin
                if (iss_reg)
                begin
                    cmp_idx_reg <= rd_idx_reg;
                    cmp_vld_reg <= 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        iss_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    cmp_vld_reg <= 1'b0;
                end
                if (!cmd.scan_age && cmp_vld_reg && !valid_reg[cmp_idx_reg]
                    && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmd.scan_age && cmp_expired)
                begin
                    expire_reg[cmp_idx_reg] <= 1'b1;
                    valid_reg[cmp_idx_reg]  <= 1'b0;
                    new_reg[cmp_idx_reg]    <= 1'b0;
                    in_use_reg              <= in_use_reg - 1'b1;
                end
            end
            if (cmd.sweep_start)
            begin
                rd_idx_reg <= '0;
            end
            if (cmd.idx_inc)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= DCW'(AW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.write_new)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                new_reg[free_idx_reg]   <= 1'b1;
                in_use_reg              <= in_use_reg + 1'b1;
            end
            if (cmd.clr_new)
            begin
                new_reg <= '0;
            end
            if (cmd.clr_all)
            begin
                valid_reg  <= '0;
                new_reg    <= '0;
                in_use_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mac_reg  <= in_mac;
            rssi_reg <= in_rssi;
            chan_reg <= in_chan;
            kind_reg <= in_kind;
            bt_reg   <= in_bt;
            now_reg  <= in_now;
        end
        if (cmd.scan_step && !cmd.scan_age)
        begin
            if (cmp_hit)
            begin
                hit_idx_reg  <= cmp_idx_reg;
                ent_mean_reg <= rd_mean_reg;
                ent_cnt_reg  <= rd_cnt_reg;
            end
            if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.mul)
        begin
            acc_reg <= acc_calc;
            n_reg   <= n_calc;
        end
        if (cmd.div_load)
        begin
            neg_reg     <= acc_reg[AW-1];
            div_q_reg   <= acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, n_reg})
            begin
                div_rem_reg <= 16'(rem_sh - {1'b0, n_reg});
                div_q_reg   <= {div_q_reg[AW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= rem_sh[15:0];
                div_q_reg   <= {div_q_reg[AW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_event_reg  <= cmd.emit_ev;
            out_in_use_reg <= 6'(in_use_reg);
            out_last_reg   <= cmd.emit_last;
            case (cmd.emit_ev)
                dst_pkg::EV_UPDATED:
                begin
                    out_mac_reg   <= mac_reg;
                    out_slot_reg  <= 5'(hit_idx_reg);
                    out_count_reg <= n_reg;
                    out_mean_reg  <= 16'(div_mean);
                end
                dst_pkg::EV_INSERTED:
                begin
                    out_mac_reg   <= mac_reg;
                    out_slot_reg  <= 5'(free_idx_reg);
                    out_count_reg <= 16'd1;
                    out_mean_reg  <= 16'(rssi_sh);
                end
                dst_pkg::EV_FULL:
                begin
                    out_mac_reg   <= mac_reg;
                    out_slot_reg  <= '0;
                    out_count_reg <= '0;
                    out_mean_reg  <= '0;
                end
                dst_pkg::EV_LOST:
                begin
                    out_mac_reg   <= rd_addr_reg;
                    out_slot_reg  <= 5'(rd_idx_reg);
                    out_count_reg <= rd_cnt_reg;
                    out_mean_reg  <= 16'(rd_mean_reg);
                end
                default:
                begin
                    out_mac_reg   <= '0;
                    out_slot_reg  <= '0;
                    out_count_reg <= '0;
                    out_mean_reg  <= '0;
                end
            endcase
        end
    end

    // Entry memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.write_hit)
        begin
            mem_lrssi[hit_idx_reg] <= rssi_reg;
            mem_mean[hit_idx_reg]  <= div_mean;
            mem_cnt[hit_idx_reg]   <= n_reg;
            mem_last[hit_idx_reg]  <= now_reg;
            if (!bt_reg)
            begin
                mem_chan[hit_idx_reg] <= chan_reg;
            end
        end
        if (cmd.write_new)
        begin
            mem_addr[free_idx_reg]  <= mac_reg;
            mem_lrssi[free_idx_reg] <= rssi_reg;
            mem_mean[free_idx_reg]  <= rssi_sh;
            mem_cnt[free_idx_reg]   <= 16'd1;
            mem_first[free_idx_reg] <= now_reg;
            mem_last[free_idx_reg]  <= now_reg;
            mem_chan[free_idx_reg]  <= bt_reg ? 8'd0 : chan_reg;
            mem_kind[free_idx_reg]  <= kind_reg;
        end
        if (rd_en)
        begin
            rd_addr_reg <= mem_addr[rd_idx_reg];
            rd_mean_reg <= mem_mean[rd_idx_reg];
            rd_cnt_reg  <= mem_cnt[rd_idx_reg];
            rd_last_reg <= mem_last[rd_idx_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_event  = out_event_reg;
    assign out_mac    = out_mac_reg;
    assign out_slot   = out_slot_reg;
    assign out_count  = out_count_reg;
    assign out_mean   = out_mean_reg;
    assign out_in_use = out_in_use_reg;
    assign out_last   = out_last_reg;

endmodule

### design/device_sighting_table_with_aging.sv
// ----------------------------------------------------------------------------
// Device sighting table with ageing
// Learning table of radio devices keyed by 48-bit address, with running-mean
// signal and idle-time removal at the end of each scan.
// ----------------------------------------------------------------------------
// The block takes one transfer at a time. A sighting walks the table one slot
// a cycle through the entry memory's single read port: a hit stops the walk
// at its slot, a miss walks every slot and then takes the first free slot or
// reports the table full. A hit then goes through the mean update, a multiply,
// a divider load and the one-bit-per-cycle divider, before the entry is
// written back. Each result waits until the output register is free, and the
// last result of a transfer is registered as the block returns to idle, ready
// for the next transfer. Begin scan and clear go straight to the done result.
// End scan runs an ageing pass over every slot, then a sweep over every slot,
// emitting a lost result per removed entry, then the done result. Results leave
// through a single output register; the next transfer is accepted while the
// last result of the previous one still waits there. The idle timeout may
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module device_sighting_table_with_aging
#(
    parameter int TABLE_ENTRIES      = dst_pkg::TABLE_ENTRIES_DEF,
    parameter int MEAN_FRACTION_BITS = dst_pkg::MEAN_FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Idle timeout in milliseconds.
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: mac[47:0], rssi[55:48], radio_channel[63:56], now_ms[95:64]
    input  logic [95:0] s_tdata,
    // tuser: mode[1:0], device_kind[3:2], from_bluetooth[4]
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: entry_mac[47:0], slot[52:48], sighting_count[68:53],
    //        mean_rssi[84:69], entries_in_use[90:85], zero[95:91]
    output logic [95:0] m_tdata,
    // tuser: event_res[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    dst_pkg::cmd_t    cmd;
    dst_pkg::status_t stat;

    logic [47:0] entry_mac;
    logic [4:0]  slot;
    logic [15:0] sighting_count;
    logic [15:0] mean_rssi;
    logic [5:0]  entries_in_use;

    // The controller only needs the mode; all payload goes to the datapath.
    dst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[1:0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dst_dp
    #(
        .TABLE_ENTRIES      (TABLE_ENTRIES),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_mac     (s_tdata[47:0]),
        .in_rssi    (s_tdata[55:48]),
        .in_chan    (s_tdata[63:56]),
        .in_kind    (s_tuser[3:2]),
        .in_bt      (s_tuser[4]),
        .in_now     (s_tdata[95:64]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_event  (m_tuser),
        .out_mac    (entry_mac),
        .out_slot   (slot),
        .out_count  (sighting_count),
        .out_mean   (mean_rssi),
        .out_in_use (entries_in_use),
        .out_last   (m_tlast)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {5'd0, entries_in_use, mean_rssi, sighting_count, slot, entry_mac};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sighting table testbench
// Drives sightings, scan markers and clears through the input stream, keeps
// its own model of the table to predict every result transfer, and compares
// each one field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_SLOTS   = dst_pkg::TABLE_ENTRIES_DEF;
    localparam int FRAC_BITS = dst_pkg::MEAN_FRACTION_BITS_DEF;
    // Long enough for an end scan with every entry removed, plus margin.
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        dst_pkg::ev_t ev;
        logic [47:0]  mac;
        logic [4:0]   slot;
        logic [15:0]  count;
        logic [15:0]  mean;
        logic [5:0]   in_use;
        logic         last;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: mac[47:0], rssi[55:48], radio_channel[63:56], now_ms[95:64]
    logic [95:0] s_tdata;
    // tuser: mode[1:0], device_kind[3:2], from_bluetooth[4]
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: entry_mac[47:0], slot[52:48], sighting_count[68:53],
    //        mean_rssi[84:69], entries_in_use[90:85], zero[95:91]
    logic [95:0] m_tdata;
    // tuser: event_res[2:0]
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Predictor copy of the table.
    logic [31:0] timeout_ms;
    logic        slot_valid [N_SLOTS];
    logic [47:0] slot_mac   [N_SLOTS];
    logic [15:0] slot_count [N_SLOTS];
    logic [15:0] slot_mean  [N_SLOTS];
    logic [31:0] slot_seen  [N_SLOTS];

    table_result_t expected_results[$];
    int            fail_count;

    // Idling controls: percentages of cycles spent idle or stalling.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    device_sighting_table_with_aging i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Builds one expected result; entries_in_use and last are filled in once
    // the whole input has been worked out.
    function automatic table_result_t make_result(dst_pkg::ev_t ev, logic [47:0] mac,
                                                  logic [4:0] slot,
                                                  logic [15:0] count,
                                                  logic [15:0] mean);
        table_result_t r;
        r.ev     = ev;
        r.mac    = mac;
        r.slot   = slot;
        r.count  = count;
        r.mean   = mean;
        r.in_use = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    // Works out the results one input transfer causes and updates the model.
    task automatic predict_table_step(logic [1:0] mode, logic [47:0] mac,
                                      logic signed [7:0] rssi, logic [31:0] now);
        table_result_t batch[$];
        int            hit;
        int            free_slot;
        int            used;
        longint        n;
        longint        acc;
        hit       = -1;
        free_slot = -1;
        used      = 0;
        if (mode == dst_pkg::MODE_SIGHT)
        begin
            for (int i = 0; i < N_SLOTS; i++)
                if (hit < 0 && slot_valid[i] && slot_mac[i] == mac)
                    hit = i;
            if (hit >= 0)
            begin
                slot_seen[hit] = now;
                if (slot_count[hit] != 16'hFFFF)
                    slot_count[hit] = slot_count[hit] + 1;
                n   = slot_count[hit];
                acc = longint'($signed(slot_mean[hit])) * (n - 1)
                    + longint'(rssi) * (longint'(1) << FRAC_BITS);
                // SystemVerilog division truncates toward zero, as required.
                slot_mean[hit] = 16'(acc / n);
                batch.insert(batch.size(), make_result(dst_pkg::EV_UPDATED, mac, 5'(hit),
                                                       slot_count[hit], slot_mean[hit]));
            end
            else
            begin
                for (int i = 0; i < N_SLOTS; i++)
                    if (free_slot < 0 && !slot_valid[i])
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    slot_valid[free_slot] = 1'b1;
                    slot_mac[free_slot]   = mac;
                    slot_count[free_slot] = 16'd1;
                    slot_mean[free_slot]  = 16'(longint'(rssi) <<< FRAC_BITS);
                    slot_seen[free_slot]  = now;
                    batch.insert(batch.size(), make_result(dst_pkg::EV_INSERTED, mac,
                                                           5'(free_slot), 16'd1,
                                                           slot_mean[free_slot]));
                end
                else
                    batch.insert(batch.size(),
                                 make_result(dst_pkg::EV_FULL, mac, '0, '0, '0));
            end
        end
        else if (mode == dst_pkg::MODE_END)
        begin
            for (int i = 0; i < N_SLOTS; i++)
                if (slot_valid[i] && (now - slot_seen[i]) > timeout_ms)
                begin
                    slot_valid[i] = 1'b0;
                    batch.insert(batch.size(), make_result(dst_pkg::EV_LOST, slot_mac[i],
                                                           5'(i), slot_count[i],
                                                           slot_mean[i]));
                end
            batch.insert(batch.size(), make_result(dst_pkg::EV_DONE, '0, '0, '0, '0));
        end
        else
        begin
            if (mode == dst_pkg::MODE_CLEAR)
                for (int i = 0; i < N_SLOTS; i++)
                    slot_valid[i] = 1'b0;
            batch.insert(batch.size(), make_result(dst_pkg::EV_DONE, '0, '0, '0, '0));
        end
        for (int i = 0; i < N_SLOTS; i++)
            if (slot_valid[i])
                used++;
        foreach (batch[i])
        begin
            batch[i].in_use = 6'(used);
            batch[i].last   = (i == batch.size() - 1);
            expected_results.insert(expected_results.size(), batch[i]);
        end
    endtask

    // Offers one input transfer and holds it until it is accepted. The valid
    // stays high afterwards so that transfers can follow back to back; drain
    // drops it.
    task automatic send_item(logic [1:0] mode, logic [47:0] mac, logic [7:0] rssi,
                             logic [7:0] chan, logic [1:0] kind, logic bt,
                             logic [31:0] now);
        while (($urandom % 100) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, chan, rssi, mac};
        s_tuser  <= {bt, kind, mode};
        predict_table_step(mode, mac, rssi, now);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the block
    // settle before anything touches the register.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        timeout_ms = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: stalls at random, or for a long counted stretch on request.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready        <= 1'b0;
        end
        else
            m_tready <= rst_n && (($urandom % 100) >= recv_stall_pct);
    end

    // Result checker: each accepted result transfer against the oldest
    // expectation.
    always @(posedge clk)
    begin
        table_result_t want;
        table_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {dst_pkg::ev_t'(m_tuser), m_tdata[47:0], m_tdata[52:48],
                   m_tdata[68:53], m_tdata[84:69], m_tdata[90:85], m_tlast};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, got %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got != want || m_tdata[95:91] != '0)
                begin
                    $display("%0t: mismatch ev/mac/slot/count/mean/used/last", $realtime);
                    $display("    expected %0d %h %0d %0d %h %0d %0b", want.ev, want.mac,
                             want.slot, want.count, want.mean, want.in_use, want.last);
                    $display("    actual   %0d %h %0d %0d %h %0d %0b", got.ev, got.mac,
                             got.slot, got.count, got.mean, got.in_use, got.last);
                    fail_count++;
                end
            end
        end
    end

    // A pool of addresses so that random sightings hit as well as miss.
    logic [47:0] mac_pool[40];
    logic [31:0] clock_ms;

    function automatic logic [47:0] pick_mac;
        return mac_pool[$urandom_range(0, 39)];
    endfunction

    task automatic sight(logic [47:0] mac, logic [7:0] rssi, logic [31:0] now);
        send_item(dst_pkg::MODE_SIGHT, mac, rssi, 8'($urandom), 2'($urandom),
                  1'($urandom), now);
    endtask

    task automatic test_directed;
        // Extreme signal values, both radios, kinds 0 and 3, a hit on the same
        // address and a wrap of the millisecond clock.
        sight(48'h0, 8'h80, 32'hFFFF_FFF0);
        sight(48'hFFFF_FFFF_FFFF, 8'h7F, 32'h0);
        sight(48'h0, 8'h7F, 32'h10);
        sight(48'h0, 8'h80, 32'h20);
        send_item(dst_pkg::MODE_SIGHT, 48'h1234_5678_9ABC, 8'hC4, 8'd255, 2'd3, 1'b1,
                  32'd30);
        send_item(dst_pkg::MODE_SIGHT, 48'h1234_5678_9ABC, 8'h00, 8'd0, 2'd0, 1'b0,
                  32'd40);
        send_item(dst_pkg::MODE_BEGIN, '1, '1, '1, '1, 1'b1, '1);
        // Fill the table to overflow.
        for (int i = 0; i < N_SLOTS; i++)
            sight(48'hA0_0000 + i, 8'($urandom), 32'd100);
        send_item(dst_pkg::MODE_END, '0, '0, '0, '0, 1'b0, 32'd60100);
        send_item(dst_pkg::MODE_END, '0, '0, '0, '0, 1'b0, 32'd60101);
        send_item(dst_pkg::MODE_CLEAR, '0, '0, '0, '0, 1'b0, '0);
    endtask

    task automatic test_random_scans(int count);
        int  pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 400);
            if (pick < 85)
                sight(pick_mac(), 8'($urandom), clock_ms);
            else if (pick < 91)
                send_item(dst_pkg::MODE_BEGIN, 48'($urandom), 8'($urandom),
                          8'($urandom), 2'($urandom), 1'($urandom), 32'($urandom));
            else if (pick < 98)
                send_item(dst_pkg::MODE_END, 48'($urandom), 8'($urandom), 8'($urandom),
                          2'($urandom), 1'($urandom), clock_ms);
            else
                send_item(dst_pkg::MODE_CLEAR, '0, '0, '0, '0, 1'b0, '0);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_back_pressure;
        hold_off_cycles = 600;
        for (int i = 0; i < 8; i++)
            sight(pick_mac(), 8'($urandom), clock_ms);
    endtask

    task automatic test_saturation;
        // Long run of hits on one address; the count only reaches about forty
        // here but the mean arithmetic gets a workout with extreme signals.
        for (int i = 0; i < 40; i++)
            sight(48'hBEEF, (i % 2) ? 8'h80 : 8'h7F, clock_ms);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        fail_count      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        timeout_ms      = dst_pkg::IDLE_TIMEOUT_RESET;
        clock_ms        = 32'hFFFF_0000;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_mac[i]   = '0;
            slot_count[i] = '0;
            slot_mean[i]  = '0;
            slot_seen[i]  = '0;
        end
        for (int i = 0; i < 40; i++)
            mac_pool[i] = {16'($urandom), 32'($urandom)};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_scans(50);
        send_idle_pct = 85;
        write_timeout(32'd0);
        test_random_scans(80);
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        write_timeout(32'hFFFF_FFFF);
        test_random_scans(80);
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        write_timeout(32'd500);
        test_random_scans(110);
        test_back_pressure();
        write_timeout(32'd1500);
        test_saturation();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_scans(40);
        drain();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
